// File: rtl/core/rwls_pkg.sv
// ----------------------------------------------------------------------------
// Running warning light sequencer package
// Widths, codes, state types and color helpers shared by the sequencer and
// its checker.
// ----------------------------------------------------------------------------
package rwls_pkg;

   localparam int IDX_W    = 11;
   localparam int BASE_W   = 10;
   localparam int COLOR_W  = 24;
   localparam int TIME_W   = 32;
   localparam int MS_W     = 16;
   localparam int LC_W     = 7;
   localparam int CNT_W    = 8;
   localparam int ACT_W    = 2;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int REG_SEL_W = 3;

   localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_START = 2'd1;
   localparam logic [ACT_W-1:0] ACT_STOP  = 2'd2;

   localparam logic [REG_SEL_W-1:0] REG_BASE_INDEX  = 3'd0;
   localparam logic [REG_SEL_W-1:0] REG_LIGHT_COUNT = 3'd1;
   localparam logic [REG_SEL_W-1:0] REG_ON_MS       = 3'd2;
   localparam logic [REG_SEL_W-1:0] REG_OFF_MS      = 3'd3;
   localparam logic [REG_SEL_W-1:0] REG_FLASH_MS    = 3'd4;
   localparam logic [REG_SEL_W-1:0] REG_RUN_COUNT   = 3'd5;
   localparam logic [REG_SEL_W-1:0] REG_FLASH_COUNT = 3'd6;
   localparam logic [REG_SEL_W-1:0] REG_COLOR_RGB   = 3'd7;

   localparam logic [BASE_W-1:0]  BASE_INDEX_RST  = 10'd0;
   localparam logic [LC_W-1:0]    LIGHT_COUNT_RST = 7'd8;
   localparam logic [MS_W-1:0]    ON_MS_RST       = 16'd2500;
   localparam logic [MS_W-1:0]    OFF_MS_RST      = 16'd1000;
   localparam logic [MS_W-1:0]    FLASH_MS_RST    = 16'd100;
   localparam logic [CNT_W-1:0]   RUN_COUNT_RST   = 8'd3;
   localparam logic [CNT_W-1:0]   FLASH_COUNT_RST = 8'd3;
   localparam logic [COLOR_W-1:0] COLOR_RGB_RST   = 24'hDE640A;

   // Chain offsets of the bright and medium pixels relative to the light.
   localparam int BRIGHT_OFS = 4;
   localparam int MEDIUM_OFS = 2;

   typedef enum logic [4:0] {
      PH_OFF        = 5'b00001,
      PH_STEP_BRIGHT = 5'b00010,
      PH_STEP_DIM   = 5'b00100,
      PH_FLASH_ON   = 5'b01000,
      PH_FLASH_HELD = 5'b10000
   } phase_type;

   typedef enum logic [3:0] {
      SQ_IDLE = 4'b0001,
      SQ_MOD  = 4'b0010,
      SQ_EMIT = 4'b0100,
      SQ_FILL = 4'b1000
   } seq_type;

   // Division by 6 is a multiply by 171 and a shift by 10, by 24 a shift by 12;
   // both are exact for 8-bit channels.
   function automatic logic [COLOR_W-1:0] color_medium(input logic [COLOR_W-1:0] c);
      logic [15:0] pr;
      logic [15:0] pb;
      pr = 16'(c[23:16]) * 16'd171;
      pb = 16'(c[7:0]) * 16'd171;
      return {2'b00, pr[15:10], 3'b000, c[15:11], 2'b00, pb[15:10]};
   endfunction

   function automatic logic [COLOR_W-1:0] color_dim(input logic [COLOR_W-1:0] c);
      logic [15:0] pr;
      logic [15:0] pg;
      logic [15:0] pb;
      pr = 16'(c[23:16]) * 16'd171;
      pg = 16'(c[15:8]) * 16'd171;
      pb = 16'(c[7:0]) * 16'd171;
      return {4'h0, pr[15:12], 4'h0, pg[15:12], 4'h0, pb[15:12]};
   endfunction

endpackage

// File: rtl/core/running_warning_light_sequencer.sv
// ----------------------------------------------------------------------------
// Running warning light sequencer
// Turns start, stop and millisecond tick commands into pixel write beats for
// a chain of LED pixels: a running light, then whole-chain flashes.
// ----------------------------------------------------------------------------
// One command is taken at a time and req_stall stays high until its writes
// are issued. A running-light step computes each pixel offset modulo the
// chain length in a shared bit-serial remainder unit, one bit per cycle, for
// the bright and medium pixels of a bright step and the one pixel of a dim
// step. Stop and the flash phases write the whole chain, the effective chain
// length (light_count limited to 1 through MAX_LIGHTS), at one beat per cycle
// while rsp_stall does not hold a pending beat. Each write leaves through an
// output register, so the next command is taken while the last beat still
// waits on rsp_stall.
module running_warning_light_sequencer
   import rwls_pkg::*;
#(
   parameter int MAX_LIGHTS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACT_W-1:0]    req_action,
   input  logic [TIME_W-1:0]   req_now_ms,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [IDX_W-1:0]    rsp_pixel_index,
   output logic [COLOR_W-1:0]  rsp_pixel_color,
   output logic                rsp_last_write,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   localparam int PosW  = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
   localparam int DivW  = PosW + 3;
   localparam int BitW  = $clog2(DivW + 1);
   localparam int CmpW  = (PosW + 1 > LC_W) ? PosW + 1 : LC_W;

   logic [BASE_W-1:0]  base_index_ff;
   logic [LC_W-1:0]    light_count_ff;
   logic [MS_W-1:0]    on_ms_ff;
   logic [MS_W-1:0]    off_ms_ff;
   logic [MS_W-1:0]    flash_ms_ff;
   logic [CNT_W-1:0]   run_count_ff;
   logic [CNT_W-1:0]   flash_count_ff;
   logic [COLOR_W-1:0] color_rgb_ff;

   phase_type          phase_ff, phase_in;
   logic [PosW-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]   runs_ff, runs_in;
   logic [CNT_W-1:0]   flashes_ff, flashes_in;
   logic [TIME_W-1:0]  deadline_ff, deadline_in;

   seq_type            seq_ff, seq_in;
   logic [PosW-1:0]    pos_work_ff, pos_work_in;
   logic [DivW-1:0]    dividend_ff, dividend_in;
   logic [LC_W-1:0]    rem_ff, rem_in;
   logic [BitW-1:0]    bit_cnt_ff, bit_cnt_in;
   logic               second_ff, second_in;
   logic [COLOR_W-1:0] emit_color_ff, emit_color_in;
   logic               emit_last_ff, emit_last_in;
   logic [LC_W-1:0]    fill_idx_ff, fill_idx_in;
   logic [COLOR_W-1:0] fill_color_ff, fill_color_in;

   logic               out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]   out_index_ff, out_index_in;
   logic [COLOR_W-1:0] out_color_ff, out_color_in;
   logic               out_last_ff, out_last_in;

   logic               cfg_wr;
   logic [LC_W-1:0]    eff_count;
   logic               req_accept;
   logic               out_free;
   logic               due;
   logic [CmpW-1:0]    next_pos;
   logic [CNT_W-1:0]   runs_inc;
   logic [CNT_W-1:0]   flashes_inc;
   logic [LC_W:0]      rem_trial;
   logic [LC_W:0]      rem_diff;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_index_ff  <= BASE_INDEX_RST;
         light_count_ff <= LIGHT_COUNT_RST;
         on_ms_ff       <= ON_MS_RST;
         off_ms_ff      <= OFF_MS_RST;
         flash_ms_ff    <= FLASH_MS_RST;
         run_count_ff   <= RUN_COUNT_RST;
         flash_count_ff <= FLASH_COUNT_RST;
         color_rgb_ff   <= COLOR_RGB_RST;
      end else if (cfg_wr) begin
         case (paddr[ADDR_W-1:2])
            REG_BASE_INDEX:  base_index_ff  <= pwdata[BASE_W-1:0];
            REG_LIGHT_COUNT: light_count_ff <= pwdata[LC_W-1:0];
            REG_ON_MS:       on_ms_ff       <= pwdata[MS_W-1:0];
            REG_OFF_MS:      off_ms_ff      <= pwdata[MS_W-1:0];
            REG_FLASH_MS:    flash_ms_ff    <= pwdata[MS_W-1:0];
            REG_RUN_COUNT:   run_count_ff   <= pwdata[CNT_W-1:0];
            REG_FLASH_COUNT: flash_count_ff <= pwdata[CNT_W-1:0];
            REG_COLOR_RGB:   color_rgb_ff   <= pwdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[ADDR_W-1:2])
         REG_BASE_INDEX:  prdata = DATA_W'(base_index_ff);
         REG_LIGHT_COUNT: prdata = DATA_W'(light_count_ff);
         REG_ON_MS:       prdata = DATA_W'(on_ms_ff);
         REG_OFF_MS:      prdata = DATA_W'(off_ms_ff);
         REG_FLASH_MS:    prdata = DATA_W'(flash_ms_ff);
         REG_RUN_COUNT:   prdata = DATA_W'(run_count_ff);
         REG_FLASH_COUNT: prdata = DATA_W'(flash_count_ff);
         REG_COLOR_RGB:   prdata = DATA_W'(color_rgb_ff);
         default:         prdata = '0;
      endcase
   end

   // A chain length of zero acts as one; lengths beyond the build limit saturate.
   always_comb begin
      if (light_count_ff == '0) begin
         eff_count = LC_W'(1);
      end else if (32'(light_count_ff) > MAX_LIGHTS) begin
         eff_count = LC_W'(MAX_LIGHTS);
      end else begin
         eff_count = light_count_ff;
      end
   end

   assign req_stall   = (seq_ff != SQ_IDLE);
   assign req_accept  = req_valid & ~req_stall;
   assign out_free    = ~out_valid_ff | ~rsp_stall;
   assign due         = (phase_ff != PH_OFF) && (req_now_ms > deadline_ff);
   assign next_pos    = CmpW'(pos_ff) + CmpW'(1);
   assign runs_inc    = runs_ff + CNT_W'(1);
   assign flashes_inc = flashes_ff + CNT_W'(1);

   // Shared remainder unit: one restoring step per cycle.
   assign rem_trial = {rem_ff, dividend_ff[DivW-1]};
   assign rem_diff  = rem_trial - {1'b0, eff_count};

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      runs_in       = runs_ff;
      flashes_in    = flashes_ff;
      deadline_in   = deadline_ff;
      seq_in        = seq_ff;
      pos_work_in   = pos_work_ff;
      dividend_in   = dividend_ff;
      rem_in        = rem_ff;
      bit_cnt_in    = bit_cnt_ff;
      second_in     = second_ff;
      emit_color_in = emit_color_ff;
      emit_last_in  = emit_last_ff;
      fill_idx_in   = fill_idx_ff;
      fill_color_in = fill_color_ff;
      out_valid_in  = out_valid_ff & rsp_stall;
      out_index_in  = out_index_ff;
      out_color_in  = out_color_ff;
      out_last_in   = out_last_ff;

      case (seq_ff)
         SQ_IDLE: begin
            rem_in      = '0;
            bit_cnt_in  = '0;
            fill_idx_in = '0;
            if (req_accept) begin
               if (req_action == ACT_START) begin
                  pos_in      = '0;
                  runs_in     = '0;
                  phase_in    = PH_STEP_BRIGHT;
                  deadline_in = '0;
               end else if (req_action == ACT_STOP) begin
                  phase_in      = PH_OFF;
                  fill_color_in = '0;
                  seq_in        = SQ_FILL;
               end else if (req_action == ACT_TICK && due) begin
                  case (phase_ff)
                     PH_STEP_BRIGHT: begin
                        pos_work_in   = pos_ff;
                        dividend_in   = DivW'(pos_ff) + DivW'(BRIGHT_OFS);
                        emit_color_in = color_rgb_ff;
                        emit_last_in  = 1'b0;
                        second_in     = 1'b1;
                        deadline_in   = req_now_ms + TIME_W'(flash_ms_ff);
                        phase_in      = PH_STEP_DIM;
                        seq_in        = SQ_MOD;
                     end
                     PH_STEP_DIM: begin
                        dividend_in   = DivW'(pos_ff);
                        emit_color_in = color_dim(color_rgb_ff);
                        emit_last_in  = 1'b1;
                        second_in     = 1'b0;
                        deadline_in   = req_now_ms + TIME_W'(on_ms_ff);
                        phase_in      = PH_STEP_BRIGHT;
                        seq_in        = SQ_MOD;
                        if (next_pos >= CmpW'(eff_count)) begin
                           pos_in = '0;
                           if (runs_inc >= run_count_ff) begin
                              runs_in    = '0;
                              flashes_in = '0;
                              phase_in   = PH_FLASH_ON;
                           end else begin
                              runs_in = runs_inc;
                           end
                        end else begin
                           pos_in = next_pos[PosW-1:0];
                        end
                     end
                     PH_FLASH_ON: begin
                        fill_color_in = color_rgb_ff;
                        deadline_in   = req_now_ms + TIME_W'(flash_ms_ff);
                        phase_in      = PH_FLASH_HELD;
                        seq_in        = SQ_FILL;
                     end
                     PH_FLASH_HELD: begin
                        fill_color_in = color_dim(color_rgb_ff);
                        flashes_in    = flashes_inc;
                        seq_in        = SQ_FILL;
                        if (flashes_inc < flash_count_ff) begin
                           deadline_in = req_now_ms + TIME_W'(off_ms_ff);
                           phase_in    = PH_FLASH_ON;
                        end else begin
                           deadline_in = req_now_ms + TIME_W'(on_ms_ff);
                           phase_in    = PH_STEP_BRIGHT;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         SQ_MOD: begin
            rem_in      = rem_diff[LC_W] ? rem_trial[LC_W-1:0] : rem_diff[LC_W-1:0];
            dividend_in = dividend_ff << 1;
            bit_cnt_in  = bit_cnt_ff + BitW'(1);
            if (bit_cnt_ff == BitW'(DivW - 1)) begin
               seq_in = SQ_EMIT;
            end
         end
         SQ_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_index_in = IDX_W'(base_index_ff) + IDX_W'(rem_ff);
               out_color_in = emit_color_ff;
               out_last_in  = emit_last_ff;
               rem_in       = '0;
               bit_cnt_in   = '0;
               if (second_ff) begin
                  second_in     = 1'b0;
                  dividend_in   = DivW'(pos_work_ff) + DivW'(MEDIUM_OFS);
                  emit_color_in = color_medium(color_rgb_ff);
                  emit_last_in  = 1'b1;
                  seq_in        = SQ_MOD;
               end else begin
                  seq_in = SQ_IDLE;
               end
            end
         end
         SQ_FILL: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_index_in = IDX_W'(base_index_ff) + IDX_W'(fill_idx_ff);
               out_color_in = fill_color_ff;
               out_last_in  = (fill_idx_ff == eff_count - LC_W'(1));
               fill_idx_in  = fill_idx_ff + LC_W'(1);
               if (fill_idx_ff == eff_count - LC_W'(1)) begin
                  seq_in = SQ_IDLE;
               end
            end
         end
         default: seq_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OFF;
         pos_ff       <= '0;
         runs_ff      <= '0;
         flashes_ff   <= '0;
         deadline_ff  <= '0;
         seq_ff       <= SQ_IDLE;
         second_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         runs_ff      <= runs_in;
         flashes_ff   <= flashes_in;
         deadline_ff  <= deadline_in;
         seq_ff       <= seq_in;
         second_ff    <= second_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_work_ff   <= pos_work_in;
      dividend_ff   <= dividend_in;
      rem_ff        <= rem_in;
      bit_cnt_ff    <= bit_cnt_in;
      emit_color_ff <= emit_color_in;
      emit_last_ff  <= emit_last_in;
      fill_idx_ff   <= fill_idx_in;
      fill_color_ff <= fill_color_in;
      out_index_ff  <= out_index_in;
      out_color_ff  <= out_color_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_index = out_index_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_last_write  = out_last_ff;

endmodule

// File: rtl/core/rwls_checker.sv
// ----------------------------------------------------------------------------
// Running warning light sequencer checker
// Port-level assertions on command handling and the write beat channel.
// ----------------------------------------------------------------------------
module rwls_checker
   import rwls_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [ACT_W-1:0]    req_action,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [IDX_W-1:0]    rsp_pixel_index,
   input logic [COLOR_W-1:0]  rsp_pixel_color,
   input logic                rsp_last_write
);

   // A stalled write beat stays and keeps its contents.
   a_beat_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_index)
         && $stable(rsp_pixel_color) && $stable(rsp_last_write))
      else $error("stalled write beat changed");

   // Start produces no writes, so the block is ready again right away.
   a_start_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == ACT_START |=> !req_stall)
      else $error("start left the block busy");

   // Stop always blanks at least one pixel, so the block goes busy.
   a_stop_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == ACT_STOP |=> req_stall)
      else $error("stop did not start blanking the chain");

   // Out of reset the block is idle with no write pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind running_warning_light_sequencer rwls_checker u_rwls_checker (.*);

// File: verif/running_warning_light_sequencer_test.sv
// ----------------------------------------------------------------------------
// Running warning light sequencer testbench
// Sends start, stop and tick commands, with a few register settings in between,
// and checks every pixel write beat against a cycle-free model of the light
// sequence. Both handshakes idle at random, and the receiver also holds off
// for a long stretch.
// ----------------------------------------------------------------------------
module running_warning_light_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rwls_pkg::*;

   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 150;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct packed {
      logic [IDX_W-1:0]   index;
      logic [COLOR_W-1:0] color;
      logic               last;
   } pixel_write_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ACT_W-1:0]    req_action = ACT_TICK;
   logic [TIME_W-1:0]   req_now_ms = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [IDX_W-1:0]    rsp_pixel_index;
   logic [COLOR_W-1:0]  rsp_pixel_color;
   logic                rsp_last_write;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   logic [BASE_W-1:0]   cfg_base = BASE_INDEX_RST;
   logic [LC_W-1:0]     cfg_lights = LIGHT_COUNT_RST;
   logic [MS_W-1:0]     cfg_on = ON_MS_RST;
   logic [MS_W-1:0]     cfg_off = OFF_MS_RST;
   logic [MS_W-1:0]     cfg_flash = FLASH_MS_RST;
   logic [CNT_W-1:0]    cfg_runs = RUN_COUNT_RST;
   logic [CNT_W-1:0]    cfg_flashes = FLASH_COUNT_RST;
   logic [COLOR_W-1:0]  cfg_color = COLOR_RGB_RST;

   phase_type           seq_phase = PH_OFF;
   logic [5:0]          seq_pos = '0;
   logic [CNT_W-1:0]    seq_runs = '0;
   logic [CNT_W-1:0]    seq_flashes = '0;
   logic [TIME_W-1:0]   seq_deadline = '0;

   pixel_write_type     pending_writes[$];
   pixel_write_type     head_write;
   int                  mismatch_count = 0;
   bit                  sender_idles = 1'b1;
   bit                  receiver_idles = 1'b1;
   bit                  hold_off_pending = 1'b0;
   logic [TIME_W-1:0]   sim_ms = '0;

   running_warning_light_sequencer DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_index(rsp_pixel_index),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_last_write(rsp_last_write),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int chain_length();
      if (cfg_lights == 0) return 1;
      if (cfg_lights > 64) return 64;
      return int'(cfg_lights);
   endfunction

   function automatic logic [COLOR_W-1:0] medium_of(input logic [COLOR_W-1:0] c);
      return {8'(c[23:16] / 6), 8'(c[15:8] / 8), 8'(c[7:0] / 6)};
   endfunction

   function automatic logic [COLOR_W-1:0] dim_of(input logic [COLOR_W-1:0] c);
      return {8'(c[23:16] / 24), 8'(c[15:8] / 24), 8'(c[7:0] / 24)};
   endfunction

   function automatic void push_write(input int offset, input logic [COLOR_W-1:0] color);
      pixel_write_type w;
      w.index = IDX_W'(int'(cfg_base) + offset);
      w.color = color;
      w.last = 1'b0;
      pending_writes.push_back(w);
   endfunction

   function automatic void fill_chain(input logic [COLOR_W-1:0] color);
      int n;
      n = chain_length();
      for (int i = 0; i < n; i++) push_write(i, color);
   endfunction

   // Advances the light sequence by one accepted command and queues the
   // pixel writes that it causes.
   function automatic void advance_sequencer(input logic [ACT_W-1:0] act,
                                             input logic [TIME_W-1:0] now);
      int n;
      int first;
      int next_pos;
      n = chain_length();
      first = pending_writes.size();
      case (act)
         ACT_START: begin
            seq_pos = '0;
            seq_runs = '0;
            seq_phase = PH_STEP_BRIGHT;
            seq_deadline = '0;
         end
         ACT_STOP: begin
            seq_phase = PH_OFF;
            fill_chain('0);
         end
         ACT_TICK: begin
            if (seq_phase != PH_OFF && now > seq_deadline) begin
               case (seq_phase)
                  PH_STEP_BRIGHT: begin
                     push_write((int'(seq_pos) + BRIGHT_OFS) % n, cfg_color);
                     push_write((int'(seq_pos) + MEDIUM_OFS) % n, medium_of(cfg_color));
                     seq_deadline = now + TIME_W'(cfg_flash);
                     seq_phase = PH_STEP_DIM;
                  end
                  PH_STEP_DIM: begin
                     seq_deadline = now + TIME_W'(cfg_on);
                     push_write(int'(seq_pos) % n, dim_of(cfg_color));
                     next_pos = int'(seq_pos) + 1;
                     seq_phase = PH_STEP_BRIGHT;
                     if (next_pos >= n) begin
                        seq_pos = '0;
                        seq_runs = seq_runs + 1'b1;
                        if (seq_runs >= cfg_runs) begin
                           seq_runs = '0;
                           seq_flashes = '0;
                           seq_phase = PH_FLASH_ON;
                        end
                     end else begin
                        seq_pos = 6'(next_pos);
                     end
                  end
                  PH_FLASH_ON: begin
                     fill_chain(cfg_color);
                     seq_deadline = now + TIME_W'(cfg_flash);
                     seq_phase = PH_FLASH_HELD;
                  end
                  default: begin
                     fill_chain(dim_of(cfg_color));
                     seq_flashes = seq_flashes + 1'b1;
                     if (seq_flashes < cfg_flashes) begin
                        seq_deadline = now + TIME_W'(cfg_off);
                        seq_phase = PH_FLASH_ON;
                     end else begin
                        seq_deadline = now + TIME_W'(cfg_on);
                        seq_phase = PH_STEP_BRIGHT;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase
      if (pending_writes.size() > first)
         pending_writes[pending_writes.size() - 1].last = 1'b1;
   endfunction

   task automatic note_mismatch(input string field, input longint unsigned want,
                                input longint unsigned got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, field, want, got);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_writes.size() == 0) begin
            note_mismatch("unexpected write, index", 0, rsp_pixel_index);
         end else begin
            head_write = pending_writes.pop_front();
            if (rsp_pixel_index !== head_write.index)
               note_mismatch("pixel_index", head_write.index, rsp_pixel_index);
            if (rsp_pixel_color !== head_write.color)
               note_mismatch("pixel_color", head_write.color, rsp_pixel_color);
            if (rsp_last_write !== head_write.last)
               note_mismatch("last_write", head_write.last, rsp_last_write);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_beat(input logic [ACT_W-1:0] act, input logic [TIME_W-1:0] now);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_now_ms <= now;
      do @(posedge clock); while (req_stall);
      advance_sequencer(act, now);
   endtask

   task automatic tick_at(input logic [TIME_W-1:0] now);
      sim_ms = now;
      send_beat(ACT_TICK, now);
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [REG_SEL_W-1:0] sel, input logic [DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {sel, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (sel)
         REG_BASE_INDEX:  cfg_base = value[BASE_W-1:0];
         REG_LIGHT_COUNT: cfg_lights = value[LC_W-1:0];
         REG_ON_MS:       cfg_on = value[MS_W-1:0];
         REG_OFF_MS:      cfg_off = value[MS_W-1:0];
         REG_FLASH_MS:    cfg_flash = value[MS_W-1:0];
         REG_RUN_COUNT:   cfg_runs = value[CNT_W-1:0];
         REG_FLASH_COUNT: cfg_flashes = value[CNT_W-1:0];
         default:         cfg_color = value[COLOR_W-1:0];
      endcase
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_settings(input int base, input int lights, input int on_ms,
                                 input int off_ms, input int flash_ms, input int runs,
                                 input int flashes, input int color);
      csr_write(REG_BASE_INDEX, base);
      csr_write(REG_LIGHT_COUNT, lights);
      csr_write(REG_ON_MS, on_ms);
      csr_write(REG_OFF_MS, off_ms);
      csr_write(REG_FLASH_MS, flash_ms);
      csr_write(REG_RUN_COUNT, runs);
      csr_write(REG_FLASH_COUNT, flashes);
      csr_write(REG_COLOR_RGB, color);
   endtask

   function automatic int pick_delay();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 6);
   endfunction

   function automatic int pick_count();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
   endfunction

   task automatic randomize_settings();
      write_settings($urandom_range(0, 1023),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12),
                     pick_delay(), pick_delay(), pick_delay(), pick_count(), pick_count(),
                     $urandom_range(0, 24'hFFFFFF));
   endtask

   // Mostly ticks that move time forward a little, so the sequence keeps
   // stepping, mixed with restarts, stops, time jumps and the unused code.
   task automatic run_traffic(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            send_beat(ACT_START, $urandom);
         end else if (pick < 7) begin
            send_beat(ACT_STOP, $urandom);
         end else if (pick < 9) begin
            send_beat(ACT_UNUSED, $urandom);
         end else if (pick < 12) begin
            tick_at($urandom);
         end else begin
            tick_at(sim_ms + $urandom_range(0, 12));
         end
      end
   endtask

   task automatic test_idle_commands();
      tick_at(32'd0);
      tick_at(32'hFFFF_FFFF);
      send_beat(ACT_UNUSED, 32'h5555_AAAA);
      send_beat(ACT_STOP, 32'd0);
      send_beat(ACT_START, 32'hAAAA_5555);
      tick_at(32'd0);
      tick_at(32'd1);
      send_beat(ACT_UNUSED, 32'd50);
      tick_at(32'd101);
      tick_at(32'd102);
      send_beat(ACT_STOP, 32'd103);
      drain_and_settle();
   endtask

   task automatic test_single_pixel_chain();
      write_settings(0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF);
      send_beat(ACT_START, 32'd0);
      for (int t = 1; t <= 6; t++) tick_at(t);
      tick_at(32'd6);
      tick_at(32'd7);
      drain_and_settle();
   endtask

   task automatic test_widest_chain();
      write_settings(1023, 127, 65535, 65535, 65535, 255, 255, 0);
      send_beat(ACT_START, 32'd0);
      tick_at(32'hFFFF_FFF0);
      tick_at(32'hFFFF_FFFF);
      tick_at(32'd5);
      send_beat(ACT_STOP, 32'd6);
      drain_and_settle();
   endtask

   task automatic test_shortened_chain();
      write_settings(200, 5, 0, 0, 0, 2, 1, 24'h123456);
      send_beat(ACT_START, 32'd0);
      for (int t = 1; t <= 6; t++) tick_at(t);
      drain_and_settle();
      csr_write(REG_LIGHT_COUNT, 2);
      tick_at(32'd7);
      tick_at(32'd8);
      tick_at(32'd9);
      drain_and_settle();
   endtask

   task automatic test_random_settings();
      for (int round = 0; round < 5; round++) begin
         randomize_settings();
         send_beat(ACT_START, $urandom);
         run_traffic(70);
         drain_and_settle();
      end
   endtask

   task automatic test_receiver_hold_off();
      write_settings(64, 16, 1, 1, 1, 1, 2, 24'h80FF40);
      send_beat(ACT_START, 32'd0);
      hold_off_pending = 1'b1;
      for (int i = 0; i < 40; i++) tick_at(sim_ms + 2);
      drain_and_settle();
   endtask

   task automatic test_steady_stream();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      randomize_settings();
      send_beat(ACT_START, $urandom);
      run_traffic(60);
      drain_and_settle();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_commands();
      test_single_pixel_chain();
      test_widest_chain();
      test_shortened_chain();
      test_random_settings();
      test_receiver_hold_off();
      test_steady_stream();
      if (mismatch_count == 0 && pending_writes.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
